// ----- rtl/dqks_pkg.sv -----
// Package for the double-ended key store with key search.
// Holds the item types, request codes and controller states; no dependencies.
package dqks_pkg;

  localparam int KeyWidth = 32;
  localparam int OccWidth = 5;

  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP     = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [KeyWidth-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic                found;
    logic [OccWidth-1:0] occupancy;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

// ----- rtl/deque_with_key_search_top.sv -----
// Double-ended key store: ring of keys in one RAM with front/back indices and a count.
// Depends on dqks_pkg and dqks_ram.
// Push: result registered in the cycle after acceptance; one push accepted every cycle while the output is not stalled.
// Lookup: scans the held keys from the front and ends early on a hit, one RAM read per cycle.
// No item is accepted while a lookup scans or while a stalled result holds the output.
// Reset clears indices, count and control; key RAM contents stay undefined until written.
module deque_with_key_search_top #(
  parameter int STORE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dqks_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dqks_pkg::out_item_t out_item_o
);
  import dqks_pkg::*;

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] res;
    if (idx == IW'(STORE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IW'(1);
    end
    return res;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
    logic [IW-1:0] res;
    if (idx == '0) begin
      res = IW'(STORE_DEPTH - 1);
    end else begin
      res = idx - IW'(1);
    end
    return res;
  endfunction

  state_e state_q, state_d;
  logic [IW-1:0] front_q, front_d;
  logic [IW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [CW-1:0] left_q, left_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic          out_valid_q;
  out_item_t     out_q, out_d;

  logic          accept;
  logic          full;
  logic          hit;
  logic          load_out;
  logic          start_scan;
  logic          scan_done;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [KeyWidth-1:0] rd_data;
  logic [31:0]   count_ext;

  dqks_ram #(
    .WIDTH(KeyWidth),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_item_i.key_value),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign full        = (count_q == CW'(STORE_DEPTH));
  assign hit         = (rd_data == key_q);
  assign count_ext   = 32'(count_d);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    front_d    = front_q;
    back_d     = back_q;
    count_d    = count_q;
    slot_d     = slot_q;
    left_d     = left_q;
    key_d      = key_q;
    load_out   = 1'b0;
    start_scan = 1'b0;
    scan_done  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = back_q;
    rd_en      = 1'b0;
    rd_addr    = slot_q;
    out_d      = out_q;
    out_d.status = STATUS_DONE;
    out_d.found  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.req_type)
            REQ_PUSH_FRONT: begin
              load_out = 1'b1;
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = idx_dec(front_q);
                front_d = idx_dec(front_q);
                count_d = count_q + CW'(1);
              end
            end
            REQ_PUSH_BACK: begin
              load_out = 1'b1;
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = back_q;
                back_d  = idx_inc(back_q);
                count_d = count_q + CW'(1);
              end
            end
            REQ_LOOKUP: begin
              if (count_q == '0) begin
                load_out = 1'b1;
              end else begin
                start_scan = 1'b1;
                rd_en      = 1'b1;
                rd_addr    = front_q;
                slot_d     = idx_inc(front_q);
                left_d     = count_q;
                key_d      = in_item_i.key_value;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = slot_q;
        slot_d  = idx_inc(slot_q);
        left_d  = left_q - CW'(1);
        if (hit || left_q == CW'(1)) begin
          scan_done   = 1'b1;
          load_out    = 1'b1;
          out_d.found = hit;
        end
      end
      default: begin
      end
    endcase

    out_d.occupancy = count_ext[OccWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    left_q <= left_d;
    key_q  <= key_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/dqks_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module dqks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/dqks_checker.sv -----
// Port-level checks for the double-ended key store, bound to the top level.
// Depends on dqks_pkg and deque_with_key_search_top.
module dqks_checker #(
  parameter int STORE_DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input dqks_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dqks_pkg::out_item_t out_item_o
);
  import dqks_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.status == STATUS_FULL && out_item_o.found))
    else $error("dropped push reports a hit");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (STORE_DEPTH > 31) || (32'(out_item_o.occupancy) <= STORE_DEPTH))
    else $error("occupancy above store depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STATUS_FULL |->
      (STORE_DEPTH > 31) || (32'(out_item_o.occupancy) == STORE_DEPTH))
    else $error("full status with store not full");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item accepted while a stalled result holds the output");

endmodule

bind deque_with_key_search_top dqks_checker #(.STORE_DEPTH(STORE_DEPTH)) u_dqks_checker (.*);

// ----- verif/deque_with_key_search_top_test.sv -----
// Self-checking testbench for deque_with_key_search_top (valid/stall on both sides).
// Depends on dqks_pkg and the RTL of the block; keeps its own copy of the key ring.
// Directed front/back pushes, full-store drops and lookups, then random items in three idling phases.
module deque_with_key_search_top_test;
  import dqks_pkg::*;

  localparam int StoreDepth = 16;
  localparam int RandomCount = 1400;
  localparam logic [1:0] ReqUnused = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t    request_queue[$];
  out_item_t   pending_outcomes[$];
  logic [31:0] key_pool[$];

  logic [31:0] ring_keys[StoreDepth];
  int          head_slot = 0;
  int          tail_slot = 0;
  int          held_keys = 0;

  logic in_taken = 1'b0;
  logic hold_off = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase = -1;
  int   error_count = 0;

  deque_with_key_search_top #(
    .STORE_DEPTH(StoreDepth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("[deque_with_key_search_top] ERROR");
    $finish;
  end

  // Apply one request to the local key ring and return the result it gives.
  function automatic out_item_t deque_outcome(in_item_t req);
    out_item_t res;
    res = '0;
    res.status = STATUS_DONE;
    case (req.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held_keys >= StoreDepth) begin
          res.status = STATUS_FULL;
        end else if (req.req_type == REQ_PUSH_FRONT) begin
          head_slot = (head_slot + StoreDepth - 1) % StoreDepth;
          ring_keys[head_slot] = req.key_value;
          held_keys++;
        end else begin
          ring_keys[tail_slot] = req.key_value;
          tail_slot = (tail_slot + 1) % StoreDepth;
          held_keys++;
        end
      end
      REQ_LOOKUP: begin
        for (int i = 0; i < held_keys && i < StoreDepth; i++) begin
          if (ring_keys[(head_slot + i) % StoreDepth] == req.key_value) res.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = held_keys[OccWidth-1:0];
    return res;
  endfunction

  function automatic void queue_request(logic [1:0] kind, logic [31:0] key);
    in_item_t req;
    req.req_type = kind;
    req.key_value = key;
    request_queue.push_back(req);
    if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) key_pool.push_back(key);
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned sel;
    logic [31:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (sel < 55) begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)] ^ (32'd1 << $urandom_range(0, 31));
    end else if (sel < 65) begin
      case ($urandom_range(0, 3))
        0: key = 32'h8000_0000;
        1: key = 32'h7FFF_FFFF;
        2: key = 32'h0000_0000;
        default: key = 32'hFFFF_FFFF;
      endcase
    end else begin
      key = $urandom();
    end
    return key;
  endfunction

  function automatic void queue_random_request();
    int unsigned sel;
    logic [1:0] kind;
    sel = $urandom_range(0, 99);
    if (sel < 60) kind = REQ_LOOKUP;
    else if (sel < 77) kind = REQ_PUSH_FRONT;
    else if (sel < 94) kind = REQ_PUSH_BACK;
    else kind = ReqUnused;
    queue_request(kind, (kind == REQ_LOOKUP) ? pick_key() : $urandom());
  endfunction

  // drive the request side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= request_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // drive the result side
  always @(negedge clk_i) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    wait (phase == 2);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    in_taken <= rst_ni && in_valid && !in_stall;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result item: status %0d found %0d occupancy %0d",
               out_item.status, out_item.found, out_item.occupancy);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_item.found);
          error_count++;
        end
        if (out_item.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_item.occupancy);
          error_count++;
        end
      end
    end
    if (rst_ni && in_valid && !in_stall) pending_outcomes.push_back(deque_outcome(in_item));
  end

  initial begin
    queue_request(REQ_LOOKUP, 32'h0000_0000);
    queue_request(REQ_PUSH_FRONT, 32'h8000_0000);
    queue_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    queue_request(REQ_PUSH_FRONT, 32'h0000_0000);
    queue_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    queue_request(REQ_LOOKUP, 32'h8000_0000);
    queue_request(REQ_LOOKUP, 32'h7FFF_FFFF);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF);
    queue_request(REQ_LOOKUP, 32'h0000_0001);
    queue_request(ReqUnused, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      queue_request((i % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom());
    end
    queue_request(REQ_PUSH_FRONT, 32'h1234_5678);
    queue_request(REQ_PUSH_BACK, 32'h8765_4321);
    queue_request(REQ_LOOKUP, key_pool[key_pool.size() - 3]);
    queue_request(REQ_LOOKUP, 32'h1234_5678);
    void'(key_pool.pop_back());
    void'(key_pool.pop_back());
    for (int p = 0; p < 3; p++) begin
      @(posedge clk_i);
      case (p)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase = p;
      repeat (RandomCount / 3) queue_random_request();
      while (request_queue.size() != 0 || in_valid) @(posedge clk_i);
    end
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[deque_with_key_search_top] OK");
    end else begin
      $display("[deque_with_key_search_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dqks_pkg.sv
rtl/dqks_ram.sv
rtl/deque_with_key_search_top.sv
rtl/dqks_checker.sv
verif/deque_with_key_search_top_test.sv
